@@ rtl/core/hamming_encode_and_syndrome_top_macros.svh @@
// Assertion macros for the checker file of this block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef HAMMING_ENCODE_AND_SYNDROME_TOP_MACROS_SVH
`define HAMMING_ENCODE_AND_SYNDROME_TOP_MACROS_SVH

// Property checked on every rising edge and ignored while reset is asserted.
`define HES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising edge, including during reset.
`define HES_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/hes_pkg.sv @@
package hes_pkg;

    localparam int CODE_BITS  = 63;
    localparam int DATA_BITS  = 57;
    localparam int SYN_BITS   = 6;
    localparam int LEN_BITS   = 6;
    localparam int PLEN_BITS  = 3;
    localparam int NSUM_BITS  = 7;
    localparam int GRP_SIZE   = 8;
    localparam int GRP_COUNT  = (CODE_BITS + GRP_SIZE - 1) / GRP_SIZE;

    localparam logic [LEN_BITS-1:0]  DATA_LEN_RESET   = 6'd4;
    localparam logic [PLEN_BITS-1:0] PARITY_LEN_RESET = 3'd3;

    typedef enum logic [0:0] {
        REG_DATA_LEN   = 1'b0,
        REG_PARITY_LEN = 1'b1
    } cfg_reg_t;

    typedef logic [CODE_BITS-1:0] code_word_t;

    // True when position k (counted from 1) is a power of two.
    function automatic logic is_parity_pos(input int k);
        return (k & (k - 1)) == 0;
    endfunction

    // Message bit index carried by data position k: the count of data
    // positions below k.
    function automatic logic [LEN_BITS-1:0] data_index(input int k);
        int cnt;
        cnt = 0;
        for (int p = 1; p < k; p++) begin
            if (!is_parity_pos(p)) begin
                cnt++;
            end
        end
        return LEN_BITS'(cnt);
    endfunction

endpackage

@@ rtl/core/hamming_encode_and_syndrome_top.sv @@
// Even-parity Hamming encoder and syndrome checker. Each input word carries a
// mode bit: in encode mode the message in data_bits is spread over the
// non-power-of-two positions of a codeword of data_len + parity_len positions
// and the parity bits at the power-of-two positions are filled in; in check
// mode the syndrome of received is reported, which is the position of a
// single bit error or zero. Nothing is corrected. The user must write the
// register pair data_len and parity_len through the cfg port only while the
// block is idle; the block itself does not enforce this. An unusable pair (too
// few parity bits, or more than 63 positions) yields a result word with
// config_error set and all other fields zero. The block takes one word every
// cycle while the output side does not stall. The three stages are input
// masking and message scatter, a first level of XOR reduction into
// eight-position groups, and the final reduction with parity insertion that
// fills the output register. A stalled output holds its word while the
// earlier stages keep filling until every stage is occupied.
module hamming_encode_and_syndrome_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  hes_pkg::cfg_reg_t                   cfg_index,
    input  logic [hes_pkg::LEN_BITS-1:0]        cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                mode,
    input  logic [hes_pkg::DATA_BITS-1:0]       data_bits,
    input  logic [hes_pkg::CODE_BITS-1:0]       received,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hes_pkg::CODE_BITS-1:0]       codeword,
    output logic [hes_pkg::SYN_BITS-1:0]        syndrome,
    output logic                                config_error
);
    import hes_pkg::*;

    // Configuration registers.
    logic [LEN_BITS-1:0]  data_len_reg;
    logic [PLEN_BITS-1:0] parity_len_reg;

    // Pipeline valid bits and stage enables.
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next;
    logic s1_en, s2_en, s3_en;

    // Stage 1: masked word, mode and setting check.
    code_word_t s1_word_reg, s1_word_next;
    logic       s1_mode_reg;
    logic       s1_bad_reg, s1_bad_next;

    // Stage 2: partial parities, one per syndrome bit and group.
    logic [SYN_BITS-1:0][GRP_COUNT-1:0] s2_part_reg, s2_part_next;
    code_word_t s2_word_reg;
    logic       s2_mode_reg;
    logic       s2_bad_reg;

    // Stage 3: output register.
    code_word_t          s3_code_reg, s3_code_next;
    logic [SYN_BITS-1:0] s3_syn_reg, s3_syn_next;
    logic                s3_err_reg;

    logic [NSUM_BITS-1:0] code_len;
    logic [7:0]           parity_span;
    logic [SYN_BITS-1:0]  syn_full;
    logic [SYN_BITS-1:0]  syn_mask;

    // Configuration writes; the register index selects the target.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            data_len_reg   <= DATA_LEN_RESET;
            parity_len_reg <= PARITY_LEN_RESET;
        end
        else if (cfg_we) begin
            case (cfg_index)
                REG_DATA_LEN:   data_len_reg   <= cfg_data;
                REG_PARITY_LEN: parity_len_reg <= cfg_data[PLEN_BITS-1:0];
                default:        data_len_reg   <= data_len_reg;
            endcase
        end
    end

    // A stage advances when it is empty or when the stage after it advances.
    assign s3_en    = !s3_valid_reg || out_ready;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    always_comb begin
        s1_valid_next = s1_en ? in_valid     : s1_valid_reg;
        s2_valid_next = s2_en ? s1_valid_reg : s2_valid_reg;
        s3_valid_next = s3_en ? s2_valid_reg : s3_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // Stage 1. The code length is data_len + parity_len. In encode mode each
    // data position takes its message bit when that bit is in use; the parity
    // positions stay clear until the last stage. In check mode the received
    // bits beyond the code length are dropped.
    assign code_len    = NSUM_BITS'(data_len_reg) + NSUM_BITS'(parity_len_reg);
    assign parity_span = 8'd1 << parity_len_reg;

    always_comb begin
        s1_bad_next = (parity_span < (8'(code_len) + 8'd1))
                   || (code_len > NSUM_BITS'(CODE_BITS));
        for (int k = 1; k <= CODE_BITS; k++) begin
            if (mode) begin
                s1_word_next[k-1] = received[k-1] && (NSUM_BITS'(k) <= code_len);
            end
            else if (is_parity_pos(k)) begin
                s1_word_next[k-1] = 1'b0;
            end
            else begin
                s1_word_next[k-1] = data_bits[data_index(k)]
                                 && (data_index(k) < data_len_reg);
            end
        end
    end

    // Stage 2. Syndrome bit b is the parity of every set position whose
    // index has bit b set; each group of eight positions is reduced here.
    always_comb begin
        for (int b = 0; b < SYN_BITS; b++) begin
            for (int g = 0; g < GRP_COUNT; g++) begin
                s2_part_next[b][g] = 1'b0;
                for (int t = 0; t < GRP_SIZE; t++) begin
                    if ((g * GRP_SIZE + t + 1 <= CODE_BITS)
                        && (((g * GRP_SIZE + t + 1) >> b) & 1) == 1) begin
                        s2_part_next[b][g] = s2_part_next[b][g]
                                           ^ s1_word_reg[g * GRP_SIZE + t];
                    end
                end
            end
        end
    end

    // Stage 3. The group parities are folded into the full syndrome. In
    // encode mode the syndrome bits of the data-only word are exactly the
    // parity bits, so they are dropped into the power-of-two positions.
    assign syn_mask = SYN_BITS'((8'd1 << parity_len_reg) - 8'd1);

    always_comb begin
        for (int b = 0; b < SYN_BITS; b++) begin
            syn_full[b] = ^s2_part_reg[b];
        end
        s3_code_next = '0;
        s3_syn_next  = '0;
        if (!s2_bad_reg) begin
            if (s2_mode_reg) begin
                s3_syn_next = syn_full & syn_mask;
            end
            else begin
                s3_code_next = s2_word_reg;
                for (int i = 0; i < SYN_BITS; i++) begin
                    s3_code_next[(1 << i) - 1] = syn_full[i];
                end
            end
        end
    end

    // Payload registers follow their stage enables and need no reset.
    always_ff @(posedge clk) begin
        if (s1_en) begin
            s1_word_reg <= s1_word_next;
            s1_mode_reg <= mode;
            s1_bad_reg  <= s1_bad_next;
        end
        if (s2_en) begin
            s2_part_reg <= s2_part_next;
            s2_word_reg <= s1_word_reg;
            s2_mode_reg <= s1_mode_reg;
            s2_bad_reg  <= s1_bad_reg;
        end
        if (s3_en) begin
            s3_code_reg <= s3_code_next;
            s3_syn_reg  <= s3_syn_next;
            s3_err_reg  <= s2_bad_reg;
        end
    end

    assign out_valid    = s3_valid_reg;
    assign codeword     = s3_code_reg;
    assign syndrome     = s3_syn_reg;
    assign config_error = s3_err_reg;

endmodule

@@ rtl/core/hes_checker.sv @@
`include "hamming_encode_and_syndrome_top_macros.svh"

module hes_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [hes_pkg::CODE_BITS-1:0] codeword,
    input logic [hes_pkg::SYN_BITS-1:0]  syndrome,
    input logic                          config_error
);
    import hes_pkg::*;

    logic [SYN_BITS-1:0]           cw_syn;
    logic [CODE_BITS+SYN_BITS:0]   out_word;
    logic                          out_stall;
    logic                          fields_zero;
    logic                          enc_word;

    assign out_word    = {codeword, syndrome, config_error};
    assign out_stall   = out_valid && !out_ready;
    assign fields_zero = (codeword == '0) && (syndrome == '0);
    assign enc_word    = out_valid && !config_error && (syndrome == '0);

    // Index XOR of the set positions of the output word; zero for any
    // properly encoded codeword.
    always_comb
    begin
        cw_syn = '0;
        for (int k = 1; k <= CODE_BITS; k++)
        begin
            if (codeword[k-1])
            begin
                cw_syn = cw_syn ^ SYN_BITS'(k);
            end
        end
    end

    `HES_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_word), "stalled word changed")
    `HES_ASSERT(a_err_zero, out_valid && config_error |-> fields_zero, "bad setting gave data")
    `HES_ASSERT(a_one_mode, out_valid && syndrome != '0 |-> codeword == '0, "both fields set")
    `HES_ASSERT(a_cw_even, enc_word |-> cw_syn == '0, "encoded word fails its own parity check")
    `HES_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid || rst_n, "output valid during reset")

endmodule

bind hamming_encode_and_syndrome_top hes_checker u_hes_checker (.*);

@@ test/hamming_encode_and_syndrome_top_test.sv @@
`timescale 1ns / 1ps

module hamming_encode_and_syndrome_top_test;

    import hes_pkg::*;

    // One result word as the block presents it on its output channel.
    typedef struct packed {
        logic [CODE_BITS-1:0] codeword;
        logic [SYN_BITS-1:0]  syndrome;
        logic                 config_error;
    } hamming_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    cfg_reg_t             cfg_index;
    logic [LEN_BITS-1:0]  cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 mode;
    logic [DATA_BITS-1:0] data_bits;
    logic [CODE_BITS-1:0] received;
    logic                 out_valid;
    logic                 out_ready;
    logic [CODE_BITS-1:0] codeword;
    logic [SYN_BITS-1:0]  syndrome;
    logic                 config_error;

    // The testbench's own copy of the two length registers. It changes only
    // while no word is in flight, so a word is always predicted with the
    // setting that the block used for it.
    int unsigned data_len_now;
    int unsigned parity_len_now;

    // Results predicted for accepted input words, oldest first.
    hamming_result_t pending_results[$];
    int unsigned fault_count;

    // Idle rates in percent for the sender and the receiver, and the number
    // of cycles for which the receiver is told to hold off entirely.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_off_left;

    hamming_encode_and_syndrome_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .data_bits    (data_bits),
        .received     (received),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .codeword     (codeword),
        .syndrome     (syndrome),
        .config_error (config_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The run is cut off here if the block stops moving words.
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // XOR of the indices of all set positions among the first n positions.
    function automatic int unsigned position_xor(logic [CODE_BITS-1:0] word, int unsigned n);
        int unsigned acc;
        acc = 0;
        for (int k = 1; k <= n; k++)
        begin
            if (word[k-1])
                acc ^= k;
        end
        return acc;
    endfunction

    // Works out the result word for one input word under the lengths m and r.
    function automatic hamming_result_t hamming_predict(int unsigned m, int unsigned r,
            logic mode_bit, logic [DATA_BITS-1:0] msg, logic [CODE_BITS-1:0] rcv);
        hamming_result_t res;
        int unsigned n;
        int unsigned j;
        int unsigned syn;
        res = '0;
        n = m + r;
        // Too few parity bits to name every position, or too many positions
        // for the codeword: the setting is unusable.
        if ((64'd1 << r) < n + 1 || n > CODE_BITS)
        begin
            res.config_error = 1'b1;
            return res;
        end
        if (!mode_bit)
        begin
            // Message bits go to the positions that are not powers of two,
            // in order; positions past the message are filled with zero.
            j = 0;
            for (int k = 1; k <= n; k++)
            begin
                if ((k & (k - 1)) != 0)
                begin
                    if (j < m && j < DATA_BITS && msg[j])
                        res.codeword[k-1] = 1'b1;
                    j++;
                end
            end
            // With the parity positions still clear, the index XOR gives the
            // parity bits directly. Parity positions beyond n are dropped.
            syn = position_xor(res.codeword, n);
            for (int i = 0; i < r; i++)
            begin
                if ((1 << i) <= n && syn[i])
                    res.codeword[(1 << i) - 1] = 1'b1;
            end
        end
        else
        begin
            syn = position_xor(rcv, n) & ((1 << r) - 1);
            res.syndrome = syn[SYN_BITS-1:0];
        end
        return res;
    endfunction

    task automatic note_fault(string what);
        fault_count++;
        if (fault_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Scoreboard. Every accepted input word gets its prediction queued on the
    // same edge, and every accepted result word is compared with the oldest
    // prediction, field by field.
    always @(posedge clk)
    begin : scoreboard
        hamming_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_results.push_back(hamming_predict(data_len_now, parity_len_now,
                                                          mode, data_bits, received));
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    note_fault($sformatf("result word with none pending: cw=%h syn=%0d err=%b",
                                         codeword, syndrome, config_error));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (codeword !== want.codeword || syndrome !== want.syndrome ||
                        config_error !== want.config_error)
                    begin
                        note_fault($sformatf(
                            "m=%0d r=%0d exp cw=%h syn=%0d err=%b got cw=%h syn=%0d err=%b",
                            data_len_now, parity_len_now, want.codeword, want.syndrome,
                            want.config_error, codeword, syndrome, config_error));
                    end
                end
            end
        end
    end

    // Receiver. A requested hold-off is served first; otherwise ready drops
    // at the current idle rate.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offers one input word, with a random number of idle cycles first, and
    // returns at the edge where it is accepted. Each falling edge sees at most
    // one assignment to in_valid.
    task automatic send_word(logic mode_bit, logic [DATA_BITS-1:0] msg,
                             logic [CODE_BITS-1:0] rcv);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= mode_bit;
        data_bits <= msg;
        received  <= rcv;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stops offering words and waits until every predicted result is back.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_length(cfg_reg_t idx, logic [LEN_BITS-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == REG_DATA_LEN)
            data_len_now = value;
        else
            parity_len_now = value[PLEN_BITS-1:0];
    endtask

    // Changes both lengths, only once the block has gone idle.
    task automatic set_lengths(int unsigned m, int unsigned r);
        drain_pipeline();
        write_length(REG_DATA_LEN, LEN_BITS'(m));
        write_length(REG_PARITY_LEN, LEN_BITS'(r));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CODE_BITS-1:0] random_code_bits();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[CODE_BITS-1:0];
    endfunction

    // A valid codeword under the current setting, with one position flipped
    // (or none) and junk above position n, which the block must ignore.
    function automatic logic [CODE_BITS-1:0] damaged_codeword(int unsigned flip_pos);
        hamming_result_t clean;
        logic [CODE_BITS-1:0] word;
        logic [CODE_BITS-1:0] above_n;
        int unsigned n;
        n = data_len_now + parity_len_now;
        clean = hamming_predict(data_len_now, parity_len_now, 1'b0,
                                DATA_BITS'(random_code_bits()), '0);
        word = clean.codeword;
        if (flip_pos > 0 && flip_pos <= CODE_BITS)
            word[flip_pos-1] = ~word[flip_pos-1];
        above_n = ~((CODE_BITS'(1) << n) - CODE_BITS'(1));
        if (n >= CODE_BITS)
            above_n = '0;
        return word | (random_code_bits() & above_n);
    endfunction

    // Mostly encodes and well-formed checks with a single error or none;
    // the rest are checks of arbitrary received bits.
    task automatic send_random_word();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(99);
        n = data_len_now + parity_len_now;
        if (n > CODE_BITS)
            n = CODE_BITS;
        if (pick < 45)
            send_word(1'b0, DATA_BITS'(random_code_bits()), random_code_bits());
        else if (pick < 85)
            send_word(1'b1, DATA_BITS'(random_code_bits()), damaged_codeword($urandom_range(n)));
        else
            send_word(1'b1, DATA_BITS'(random_code_bits()), random_code_bits());
    endtask

    // The reset setting of four message bits and three parity bits, which is
    // the classic (7,4) code.
    task automatic test_reset_setting();
        send_word(1'b0, '0, '0);
        send_word(1'b0, '1, '0);                // bits above the message are ignored
        send_word(1'b0, DATA_BITS'(1), random_code_bits());
        send_word(1'b1, DATA_BITS'(random_code_bits()), '0);
        send_word(1'b1, '0, CODE_BITS'(1) << 4);  // single error at position five
        send_word(1'b1, '0, '1);                // received bits above position seven ignored
    endtask

    // Largest and smallest codes, zero lengths, oversized parity counts and
    // unusable settings.
    task automatic test_extreme_settings();
        set_lengths(57, 6);
        send_word(1'b0, '1, '0);
        send_word(1'b0, '0, '1);
        send_word(1'b1, '0, '1);
        send_word(1'b1, '0, damaged_codeword(63));
        set_lengths(1, 2);
        send_word(1'b0, DATA_BITS'(1), '0);
        send_word(1'b1, '0, CODE_BITS'(7));
        // Zero lengths pass the usability test and give an all-zero code.
        set_lengths(0, 0);
        send_word(1'b0, '1, '1);
        send_word(1'b1, '1, '1);
        set_lengths(0, 1);
        send_word(1'b1, '1, '1);
        // Two parity bits cannot cover six positions.
        set_lengths(4, 2);
        send_word(1'b0, '1, '1);
        send_word(1'b1, '1, '1);
        // Sixty-four positions do not fit in the codeword.
        set_lengths(58, 6);
        send_word(1'b0, '1, '0);
        // More parity bits than needed: parity position 32 lies beyond n.
        set_lengths(10, 6);
        send_word(1'b0, '1, '0);
        send_word(1'b1, '0, damaged_codeword(16));
        set_lengths(56, 7);
        send_word(1'b0, '1, '0);
        send_word(1'b1, '0, '1);
        set_lengths(63, 7);
        send_word(1'b1, '1, '1);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the pipeline fills and in_ready has to drop.
    task automatic test_output_hold_off();
        set_lengths(26, 5);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge clk);
        hold_off_left = 300;
        repeat (40) send_random_word();
        drain_pipeline();
    endtask

    // Random words over random settings, under three idling regimes.
    task automatic test_random_traffic();
        int unsigned m;
        int unsigned r;
        int unsigned top;
        for (int regime = 0; regime < 3; regime++)
        begin
            case (regime)
                0:
                begin
                    send_idle_pct = 37;
                    recv_idle_pct = 78;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_idle_pct = 37;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int phase = 0; phase < 4; phase++)
            begin
                if ($urandom_range(4) == 0)
                begin
                    // Any register values at all, often unusable.
                    m = $urandom_range(63);
                    r = $urandom_range(7);
                end
                else
                begin
                    // A usable setting, often the longest message it allows.
                    r = $urandom_range(7, 2);
                    top = (1 << r) - r - 1;
                    if (top > CODE_BITS - r)
                        top = CODE_BITS - r;
                    m = $urandom_range(1) ? top : $urandom_range(top);
                end
                set_lengths(m, r);
                repeat (100) send_random_word();
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_DATA_LEN;
        cfg_data       = '0;
        in_valid       = 1'b0;
        mode           = 1'b0;
        data_bits      = '0;
        received       = '0;
        data_len_now   = DATA_LEN_RESET;
        parity_len_now = PARITY_LEN_RESET;
        fault_count    = 0;
        send_idle_pct  = 37;
        recv_idle_pct  = 78;
        hold_off_left  = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_reset_setting();
        test_extreme_settings();
        test_output_hold_off();
        test_random_traffic();
        drain_pipeline();

        if (pending_results.size() != 0)
            note_fault($sformatf("%0d result words never arrived", pending_results.size()));
        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/hes_pkg.sv
rtl/core/hamming_encode_and_syndrome_top.sv
rtl/core/hes_checker.sv
test/hamming_encode_and_syndrome_top_test.sv
